// ===== rtl/cws_pkg.sv =====
// ----------------------------------------------------------------------------
// Cumulative weight sampler package
// Shared widths and request codes for the cumulative weight sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package cws_pkg;

  // Width of one running sum, of the reported total and of the payload fields.
  localparam int unsigned SUM_W      = 42;
  localparam int unsigned WEIGHT_W   = 32;
  localparam int unsigned FRACTION_W = 32;
  localparam int unsigned INDEX_W    = 10;
  localparam int unsigned COUNT_W    = 11;

  // Request modes.
  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_SAMPLE = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_ZERO  = 2'd3
  } status_e;

endpackage

`default_nettype wire

// ===== rtl/cws_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cws_ram #(
  parameter int unsigned WIDTH = 42,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/cumulative_weight_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// Cumulative weight sampler unit
// Keeps a table of running weight sums and draws indexes by inverse CDF.
// ----------------------------------------------------------------------------
// Usage: requests enter on the input channel (in_valid_i / in_stall_o) with a
// mode, a weight and a random fraction. Append stores total + weight as a new
// table entry, clear empties the table, sample scales the fraction by the
// total and returns the first entry whose running sum exceeds that value.
// Every request returns exactly one result on the output channel
// (out_valid_o / out_stall_i) with index, total, count and status.
// Append, clear and unknown modes go from acceptance through the S_DONE state
// into the output register. A sample on a table of two or more entries first
// passes S_MUL_LO, S_MUL_HI and S_KEY, then takes at most ceil(log2(count))
// binary search steps in S_SEARCH: two passes through the shared 32x32
// multiplier, one key add, and one table RAM read per binary search step.
// One request is in work at a time; the next is accepted once the result has
// moved to the output register, even while that result is still stalled.
// Reset empties the table (count and total go to zero); RAM contents are not
// cleared, since only entries below the count are ever used. While the
// receiver stalls, the finished result stays in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cumulative_weight_sampler_unit #(
  parameter int unsigned MAX_OUTCOMES = 1024,
  parameter int unsigned WEIGHT_BITS  = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Request channel
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [1:0]                          mode_i,
  input  wire logic [cws_pkg::WEIGHT_W-1:0]        weight_i,
  input  wire logic [cws_pkg::FRACTION_W-1:0]      random_fraction_i,
  // Result channel
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic      [cws_pkg::INDEX_W-1:0]         index_o,
  output logic      [cws_pkg::SUM_W-1:0]           total_o,
  output logic      [cws_pkg::COUNT_W-1:0]         count_o,
  output logic      [1:0]                          status_o
);

  localparam int unsigned IdxW  = $clog2(MAX_OUTCOMES);
  localparam int unsigned CntW  = $clog2(MAX_OUTCOMES + 1);
  localparam int unsigned WUse  = (WEIGHT_BITS < cws_pkg::WEIGHT_W) ?
                                  WEIGHT_BITS : cws_pkg::WEIGHT_W;
  localparam int unsigned SumW  = cws_pkg::SUM_W;
  localparam int unsigned SumXW = SumW + 1;
  localparam int unsigned MulW  = cws_pkg::FRACTION_W;
  localparam logic [CntW-1:0] CountMax = CntW'(MAX_OUTCOMES);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MUL_LO = 6'b000010,
    S_MUL_HI = 6'b000100,
    S_KEY    = 6'b001000,
    S_SEARCH = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Table state: entry count and a copy of the last running sum.
  logic [CntW-1:0] count_q, count_d;
  logic [SumW-1:0] total_q, total_d;

  // Per-request working registers.
  logic [MulW-1:0]   frac_q, frac_d;
  logic [2*MulW-1:0] plo_q, plo_d;
  logic [SumW-1:0]   phi_q, phi_d;
  logic [SumW-1:0]   key_q, key_d;
  logic [IdxW-1:0]   lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [IdxW-1:0]   res_index_q, res_index_d;
  logic [1:0]        res_status_q, res_status_d;

  // Output register.
  logic                     out_valid_q, out_valid_d;
  logic [cws_pkg::INDEX_W-1:0] out_index_q;
  logic [SumW-1:0]          out_total_q;
  logic [cws_pkg::COUNT_W-1:0] out_count_q;
  logic [1:0]               out_status_q;
  logic                     out_load;

  // RAM port.
  logic            ram_we;
  logic [IdxW-1:0] ram_addr;
  logic [SumW-1:0] ram_wdata;
  logic [SumW-1:0] ram_rdata;

  // Datapath terms.
  logic              in_accept;
  logic [WUse-1:0]   weight_eff;
  logic [SumXW-1:0]  sum_ext;
  logic [SumW-1:0]   sum_sat;
  logic [MulW-1:0]   mul_b;
  logic [2*MulW-1:0] product;
  logic [SumW-1:0]   key_sum;
  logic [IdxW-1:0]   last_idx;
  logic              above;
  logic [IdxW-1:0]   lo_n, hi_n, mid_n;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // Saturating append sum.
  assign weight_eff = weight_i[WUse-1:0];
  assign sum_ext    = {1'b0, total_q} + SumXW'(weight_eff);
  assign sum_sat    = sum_ext[SumW] ? {SumW{1'b1}} : sum_ext[SumW-1:0];

  // Shared multiplier: low 32 bits of the total first, then the high bits.
  assign mul_b   = (state_q == S_MUL_LO) ? total_q[MulW-1:0]
                                         : MulW'(total_q[SumW-1:MulW]);
  assign product = frac_q * mul_b;
  assign key_sum = phi_q + SumW'(plo_q[2*MulW-1:MulW]);

  // One binary search step on the entry read in the previous cycle.
  assign last_idx = IdxW'(count_q - CntW'(1));
  assign above    = (ram_rdata > key_q);
  assign lo_n     = above ? lo_q : mid_q + IdxW'(1);
  assign hi_n     = above ? mid_q : hi_q;
  assign mid_n    = lo_n + ((hi_n - lo_n) >> 1);

  // Request sequencer.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    total_d      = total_q;
    frac_d       = frac_q;
    plo_d        = plo_q;
    phi_d        = phi_q;
    key_d        = key_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    res_index_d  = res_index_q;
    res_status_d = res_status_q;
    ram_we       = 1'b0;
    ram_addr     = mid_q;
    ram_wdata    = sum_sat;
    out_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        ram_addr = count_q[IdxW-1:0];
        if (in_accept) begin
          res_index_d  = '0;
          res_status_d = cws_pkg::STATUS_OK;
          frac_d       = random_fraction_i;
          state_d      = S_DONE;
          unique case (cws_pkg::mode_e'(mode_i))
            cws_pkg::MODE_APPEND: begin
              if (count_q >= CountMax) begin
                res_status_d = cws_pkg::STATUS_FULL;
              end else begin
                ram_we  = 1'b1;
                total_d = sum_sat;
                count_d = count_q + CntW'(1);
              end
            end
            cws_pkg::MODE_SAMPLE: begin
              if (count_q == '0) begin
                res_status_d = cws_pkg::STATUS_EMPTY;
              end else if (total_q == '0) begin
                res_status_d = cws_pkg::STATUS_ZERO;
              end else if (count_q != CntW'(1)) begin
                state_d = S_MUL_LO;
              end
            end
            cws_pkg::MODE_CLEAR: begin
              count_d = '0;
              total_d = '0;
            end
            default: begin
              // Unused mode: table untouched.
            end
          endcase
        end
      end
      S_MUL_LO: begin
        plo_d   = product;
        state_d = S_MUL_HI;
      end
      S_MUL_HI: begin
        phi_d   = product[SumW-1:0];
        state_d = S_KEY;
      end
      S_KEY: begin
        // Form the key and fetch the first midpoint of the whole table.
        key_d    = key_sum;
        lo_d     = '0;
        hi_d     = last_idx;
        mid_d    = last_idx >> 1;
        ram_addr = last_idx >> 1;
        state_d  = S_SEARCH;
      end
      S_SEARCH: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n < hi_n) begin
          mid_d    = mid_n;
          ram_addr = mid_n;
        end else begin
          res_index_d = lo_n;
          state_d     = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid follows loads and completed handshakes.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and table state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    frac_q       <= frac_d;
    plo_q        <= plo_d;
    phi_q        <= phi_d;
    key_q        <= key_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    mid_q        <= mid_d;
    res_index_q  <= res_index_d;
    res_status_q <= res_status_d;
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_index_q  <= cws_pkg::INDEX_W'(res_index_q);
      out_total_q  <= total_q;
      out_count_q  <= cws_pkg::COUNT_W'(count_q);
      out_status_q <= res_status_q;
    end
  end

  // Running sum table.
  cws_ram #(
    .WIDTH (SumW),
    .DEPTH (MAX_OUTCOMES)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign index_o     = out_index_q;
  assign total_o     = out_total_q;
  assign count_o     = out_count_q;
  assign status_o    = out_status_q;

endmodule

`default_nettype wire

// ===== tb/cumulative_weight_sampler_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Cumulative weight sampler unit testbench
// Drives append, sample, clear and unused-mode requests into the sampler and
// checks every result against a predictor that keeps its own table of running
// sums. It starts with a directed sweep of corner cases and then runs random
// sets of appends, samples, clears and unused-mode requests. A later stretch
// fills the table to its full depth. Both channels idle at random, and there
// is one long receiver hold-off and one full drain pause.
// ----------------------------------------------------------------------------

module cumulative_weight_sampler_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH  = 1024;
  localparam logic [1:0]  MODE_UNUSED  = 2'd3;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // One result as the block reports it.
  typedef struct packed {
    logic [cws_pkg::INDEX_W-1:0] index;
    logic [cws_pkg::SUM_W-1:0]   total;
    logic [cws_pkg::COUNT_W-1:0] count;
    cws_pkg::status_e            status;
  } draw_result_t;

  // Predicts each result from its own copy of the table of running sums and
  // checks the block's results against those predictions in order.
  class sampler_scoreboard;
    logic [cws_pkg::SUM_W-1:0] sums [TABLE_DEPTH];
    int unsigned      n_entries;
    draw_result_t     awaited_draws [$];
    int unsigned      n_requests;
    int unsigned      n_checked;
    int unsigned      n_errors;
    int unsigned      peak_entries;
    int unsigned      mode_hits [4];
    int unsigned      status_hits [4];

    function int unsigned entries();
      return n_entries;
    endfunction

    function int unsigned pending();
      return awaited_draws.size();
    endfunction

    function logic [cws_pkg::SUM_W-1:0] table_total();
      return (n_entries == 0) ? '0 : sums[n_entries-1];
    endfunction

    // Binary search for the first entry whose running sum lies above the key.
    function int unsigned first_above(logic [cws_pkg::SUM_W-1:0] key);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = n_entries - 1;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (sums[mid] > key) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
      return lo;
    endfunction

    // Applies one accepted request to the table and queues its result.
    function void note_request(logic [1:0] mode, logic [cws_pkg::WEIGHT_W-1:0] weight,
                               logic [cws_pkg::FRACTION_W-1:0] frac);
      draw_result_t                                    res;
      logic [cws_pkg::SUM_W:0]                         grown;
      logic [cws_pkg::SUM_W+cws_pkg::FRACTION_W-1:0]   product;
      logic [cws_pkg::SUM_W-1:0]                       total;
      logic [cws_pkg::SUM_W-1:0]                       scaled;
      res = '0;
      res.status = cws_pkg::STATUS_OK;
      total = table_total();
      case (mode)
        cws_pkg::MODE_APPEND: begin
          if (n_entries >= TABLE_DEPTH) begin
            res.status = cws_pkg::STATUS_FULL;
          end else begin
            // Running sums saturate at the top of the sum width.
            grown = total + weight;
            sums[n_entries] = grown[cws_pkg::SUM_W] ? '1 : grown[cws_pkg::SUM_W-1:0];
            n_entries++;
          end
        end
        cws_pkg::MODE_SAMPLE: begin
          if (n_entries == 0) begin
            res.status = cws_pkg::STATUS_EMPTY;
          end else if (total == 0) begin
            res.status = cws_pkg::STATUS_ZERO;
          end else if (n_entries > 1) begin
            // Exact floor of fraction times total over 2^32.
            product = frac * total;
            scaled = product[cws_pkg::SUM_W+cws_pkg::FRACTION_W-1:
                             cws_pkg::FRACTION_W];
            res.index = cws_pkg::INDEX_W'(first_above(scaled));
          end
        end
        cws_pkg::MODE_CLEAR: begin
          n_entries = 0;
        end
        default: begin
        end
      endcase
      res.total = table_total();
      res.count = cws_pkg::COUNT_W'(n_entries);
      awaited_draws.insert(awaited_draws.size(), res);
      n_requests++;
      mode_hits[mode]++;
      if (n_entries > peak_entries) peak_entries = n_entries;
    endfunction

    // Compares one delivered result with the oldest prediction.
    function void check_result(draw_result_t got);
      draw_result_t want;
      if (awaited_draws.size() == 0) begin
        $error("unexpected result: index %0d total %0d count %0d status %0d",
               got.index, got.total, got.count, got.status);
        n_errors++;
        return;
      end
      want = awaited_draws.pop_front();
      n_checked++;
      status_hits[want.status]++;
      if (got.index !== want.index) begin
        $error("index mismatch: expected %0d, got %0d", want.index, got.index);
        n_errors++;
      end
      if (got.total !== want.total) begin
        $error("total mismatch: expected %0d, got %0d", want.total, got.total);
        n_errors++;
      end
      if (got.count !== want.count) begin
        $error("count mismatch: expected %0d, got %0d", want.count, got.count);
        n_errors++;
      end
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, got %0d", want.status, got.status);
        n_errors++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [1:0]                     mode = cws_pkg::MODE_CLEAR;
  logic [cws_pkg::WEIGHT_W-1:0]   weight = '0;
  logic [cws_pkg::FRACTION_W-1:0] fraction = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [cws_pkg::INDEX_W-1:0]    index;
  logic [cws_pkg::SUM_W-1:0]      total;
  logic [cws_pkg::COUNT_W-1:0]    count;
  logic [1:0]                     status;

  sampler_scoreboard sb;
  bit                quiet = 1'b0;
  int unsigned       hold_asks = 0;
  int unsigned       hold_served = 0;
  int unsigned       stall_left = 0;
  int unsigned       cycles = 0;

  cumulative_weight_sampler_unit dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .mode_i            (mode),
    .weight_i          (weight),
    .random_fraction_i (fraction),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .index_o           (index),
    .total_o           (total),
    .count_o           (count),
    .status_o          (status)
  );

  always #5 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus a long hold-off when one is asked for.
  always @(negedge clk) begin
    if (hold_asks != hold_served) begin
      hold_served = hold_asks;
      stall_left = HOLD_CYCLES;
    end else if (quiet) begin
      stall_left = 0;
    end else if (stall_left == 0 && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 15);
    end
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  // Result monitor.
  always @(posedge clk) begin
    draw_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.index = index;
      got.total = total;
      got.count = count;
      got.status = cws_pkg::status_e'(status);
      sb.check_result(got);
    end
  end

  function automatic logic [cws_pkg::WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return $urandom_range(1, 16);
      3: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [cws_pkg::FRACTION_W-1:0] rand_fraction();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Offers one request, after a random gap, and waits until it is taken.
  task automatic send_req(input logic [1:0] req_mode,
                          input logic [cws_pkg::WEIGHT_W-1:0] req_weight,
                          input logic [cws_pkg::FRACTION_W-1:0] req_fraction);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 15);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    mode <= req_mode;
    weight <= req_weight;
    fraction <= req_fraction;
    do @(posedge clk); while (in_stall);
    sb.note_request(req_mode, req_weight, req_fraction);
  endtask

  // Stops offering and waits until every predicted result has arrived.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // A set of appends, samples, clears and unused-mode requests on a table grown up to the given depth.
  task automatic run_set(input int unsigned depth, input int unsigned n_ops);
    int unsigned pick;
    if ($urandom_range(0, 9) != 0) send_req(cws_pkg::MODE_CLEAR, $urandom, $urandom);
    repeat (n_ops) begin
      pick = $urandom_range(0, 99);
      if (pick < 45 && sb.entries() < depth) begin
        send_req(cws_pkg::MODE_APPEND, rand_weight(), $urandom);
      end else if (pick < 94) begin
        send_req(cws_pkg::MODE_SAMPLE, $urandom, rand_fraction());
      end else if (pick < 97) begin
        send_req(cws_pkg::MODE_CLEAR, $urandom, $urandom);
      end else begin
        send_req(MODE_UNUSED, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed corner cases: empty table, zero totals, a single entry,
    // extreme weights and fractions, and the unused mode.
    send_req(cws_pkg::MODE_SAMPLE, 32'h0000_0000, 32'h1234_5678);
    send_req(cws_pkg::MODE_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(MODE_UNUSED, 32'h0000_0000, 32'h0000_0000);
    send_req(cws_pkg::MODE_APPEND, 32'h0000_0000, 32'h0000_0000);
    send_req(cws_pkg::MODE_SAMPLE, 32'h0000_0000, 32'h8000_0000);
    send_req(cws_pkg::MODE_APPEND, 32'h0000_0000, 32'hFFFF_FFFF);
    send_req(cws_pkg::MODE_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(cws_pkg::MODE_CLEAR, 32'h0000_0000, 32'h0000_0000);
    send_req(cws_pkg::MODE_APPEND, 32'hFFFF_FFFF, 32'h0000_0000);
    send_req(cws_pkg::MODE_SAMPLE, 32'h0000_0000, 32'h0000_0000);
    send_req(cws_pkg::MODE_SAMPLE, 32'h0000_0000, 32'hFFFF_FFFF);
    // A zero-weight entry in the middle must never be chosen.
    send_req(cws_pkg::MODE_APPEND, 32'h0000_0000, 32'h0000_0000);
    send_req(cws_pkg::MODE_APPEND, 32'h0000_0001, 32'h0000_0000);
    send_req(cws_pkg::MODE_APPEND, 32'hFFFF_FFFF, 32'h0000_0000);
    send_req(cws_pkg::MODE_SAMPLE, 32'h0000_0000, 32'h0000_0000);
    send_req(cws_pkg::MODE_SAMPLE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_req(cws_pkg::MODE_SAMPLE, 32'h0000_0000, 32'h8000_0000);
    send_req(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(cws_pkg::MODE_APPEND, 32'hAAAA_AAAA, 32'h5555_5555);
    send_req(cws_pkg::MODE_SAMPLE, 32'h5555_5555, 32'h5555_5555);
    send_req(cws_pkg::MODE_SAMPLE, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
    send_req(cws_pkg::MODE_CLEAR, 32'h0000_0000, 32'h0000_0000);
    send_req(cws_pkg::MODE_SAMPLE, 32'h0000_0000, 32'h4000_0000);

    // Random sets, mostly on shallow tables.
    while (sb.n_requests < 420) begin
      if ($urandom_range(0, 7) == 0) begin
        run_set($urandom_range(41, 200), $urandom_range(40, 120));
      end else begin
        run_set($urandom_range(1, 40), $urandom_range(10, 60));
      end
    end

    // Long receiver hold-off while requests keep coming, then a full drain.
    hold_asks++;
    run_set(30, 40);
    wait_drained();

    // Fill the table to its full depth, then push past it.
    send_req(cws_pkg::MODE_CLEAR, $urandom, $urandom);
    while (sb.entries() < TABLE_DEPTH) begin
      if ($urandom_range(0, 9) == 0) begin
        send_req(cws_pkg::MODE_SAMPLE, $urandom, rand_fraction());
      end else begin
        send_req(cws_pkg::MODE_APPEND, rand_weight(), $urandom);
      end
    end
    repeat (4) send_req(cws_pkg::MODE_APPEND, rand_weight(), $urandom);
    send_req(cws_pkg::MODE_SAMPLE, $urandom, 32'h0000_0000);
    send_req(cws_pkg::MODE_SAMPLE, $urandom, 32'hFFFF_FFFF);
    repeat (10) send_req(cws_pkg::MODE_SAMPLE, $urandom, rand_fraction());
    send_req(MODE_UNUSED, $urandom, $urandom);

    // Last stretch with no idling on either side.
    quiet = 1'b1;
    while (sb.n_requests < 1760) run_set($urandom_range(1, 40), $urandom_range(10, 60));

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d appends, %0d samples, %0d clears, %0d unused mode.",
             sb.n_requests, sb.mode_hits[cws_pkg::MODE_APPEND],
             sb.mode_hits[cws_pkg::MODE_SAMPLE], sb.mode_hits[cws_pkg::MODE_CLEAR],
             sb.mode_hits[MODE_UNUSED]);
    $display("Checked %0d results (ok %0d, full %0d, empty %0d, zero %0d), peak depth %0d.",
             sb.n_checked, sb.status_hits[cws_pkg::STATUS_OK],
             sb.status_hits[cws_pkg::STATUS_FULL], sb.status_hits[cws_pkg::STATUS_EMPTY],
             sb.status_hits[cws_pkg::STATUS_ZERO], sb.peak_entries);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
